@@ rtl/multiswitch_ppm_slot_sequencer_assert.svh @@
// Assertion macros shared by the multi-switch slot sequencer RTL.
`ifndef MULTISWITCH_PPM_SLOT_SEQUENCER_ASSERT_SVH
`define MULTISWITCH_PPM_SLOT_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MSPS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/msps_pkg.sv @@
// Types and constants of the multi-switch slot sequencer.
package msps_pkg;

  localparam int unsigned SwitchCount = 8;
  localparam int unsigned WidthW      = 16;

  // Frame mode codes.
  localparam logic [2:0] MODE_TEN_LONG   = 3'd0;
  localparam logic [2:0] MODE_SIX        = 3'd1;
  localparam logic [2:0] MODE_NINE_REV   = 3'd2;
  localparam logic [2:0] MODE_NINE_SHORT = 3'd3;
  localparam logic [2:0] MODE_SEVENTEEN  = 3'd4;
  localparam logic [2:0] MODE_TEN_SHORT  = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] REG_FRAME_MODE    = 3'd0;
  localparam logic [2:0] REG_SYNC_OFFSET   = 3'd1;
  localparam logic [2:0] REG_SWITCH_OFFSET = 3'd2;
  localparam logic [2:0] REG_WIDTH_MAX     = 3'd3;
  localparam logic [2:0] REG_WIDTH_MIN     = 3'd4;
  localparam logic [2:0] REG_WIDTH_CENTER  = 3'd5;
  localparam logic [2:0] REG_PASSTHRU_MASK = 3'd6;

  // Switch state codes.
  localparam logic [1:0] SW_OFF    = 2'd0;
  localparam logic [1:0] SW_STEADY = 2'd1;
  localparam logic [1:0] SW_BLINK1 = 2'd2;
  localparam logic [1:0] SW_BLINK2 = 2'd3;

  typedef struct packed {
    logic [2:0]        frame_mode;
    logic [WidthW-1:0] sync_offset;
    logic [WidthW-1:0] switch_offset;
    logic [WidthW-1:0] width_max;
    logic [WidthW-1:0] width_min;
    logic [WidthW-1:0] width_center;
    logic [7:0]        passthru_mask;
  } cfg_t;

  typedef struct packed {
    logic [3:0] ten;
    logic [3:0] nine;
    logic [2:0] six;
    logic [4:0] seventeen;
  } cnt_t;

  typedef struct packed {
    logic [WidthW-1:0] pulse_width;
    logic              is_sync;
    logic              is_passthru;
    logic [3:0]        slot_channel;
  } slot_t;

endpackage

@@ rtl/msps_slot_gen.sv @@
// Slot decoder: picks the slot of the active frame and its pulse width.
module msps_slot_gen (
  input  msps_pkg::cfg_t   cfg_i,
  input  msps_pkg::cnt_t   cnt_i,
  input  logic [15:0]      states_i,
  output msps_pkg::slot_t  slot_o,
  output msps_pkg::cnt_t   cnt_o
);

  logic [15:0] long_sync;
  logic [15:0] short_sync;
  logic [15:0] lvl_high;
  logic [15:0] lvl_low;
  logic [2:0]  n_ten;
  logic [2:0]  n_six;
  logic [2:0]  n_rev;
  logic [2:0]  n_nine;
  logic [3:0]  n_sub;
  logic [3:0]  rev_full;

  // Pulse levels, all wrapping modulo 65536.
  assign long_sync  = cfg_i.width_max + cfg_i.sync_offset;
  assign short_sync = cfg_i.width_min - cfg_i.sync_offset;
  assign lvl_high   = cfg_i.width_max - cfg_i.switch_offset;
  assign lvl_low    = cfg_i.width_min + cfg_i.switch_offset;

  // Switch index of each frame layout; counters never leave their ranges.
  assign n_ten    = 3'(cnt_i.ten - 4'd2);
  assign n_six    = cnt_i.six - 3'd2;
  assign rev_full = 4'(msps_pkg::SwitchCount) - cnt_i.nine;
  assign n_rev    = rev_full[2:0];
  assign n_nine   = 3'(cnt_i.nine - 4'd1);
  assign n_sub    = 4'(cnt_i.seventeen - 5'd1);

  function automatic msps_pkg::slot_t three_level(input logic [2:0] n);
    msps_pkg::slot_t r;
    logic [1:0]      s;
    s = states_i[2*n +: 2];
    r.is_sync      = 1'b0;
    r.slot_channel = {1'b0, n};
    if (cfg_i.passthru_mask[n]) begin
      r.pulse_width = '0;
      r.is_passthru = 1'b1;
    end else begin
      r.is_passthru = 1'b0;
      case (s)
        msps_pkg::SW_STEADY: r.pulse_width = lvl_high;
        msps_pkg::SW_BLINK1: r.pulse_width = lvl_low;
        default:             r.pulse_width = cfg_i.width_center;
      endcase
    end
    return r;
  endfunction

  function automatic msps_pkg::slot_t sync_slot(input logic [15:0] w);
    msps_pkg::slot_t r;
    r.pulse_width  = w;
    r.is_sync      = 1'b1;
    r.is_passthru  = 1'b0;
    r.slot_channel = '0;
    return r;
  endfunction

  // Slot selection by mode; only the active counter advances.
  always_comb begin
    logic [1:0] s;
    cnt_o = cnt_i;
    s     = '0;
    case (cfg_i.frame_mode)
      msps_pkg::MODE_SIX: begin
        slot_o    = (cnt_i.six < 3'd2) ? sync_slot(long_sync) : three_level(n_six);
        cnt_o.six = (cnt_i.six >= 3'd5) ? 3'd0 : cnt_i.six + 3'd1;
      end
      msps_pkg::MODE_NINE_REV: begin
        slot_o     = (cnt_i.nine == 4'd0) ? sync_slot(short_sync) : three_level(n_rev);
        cnt_o.nine = (cnt_i.nine >= 4'd8) ? 4'd0 : cnt_i.nine + 4'd1;
      end
      msps_pkg::MODE_NINE_SHORT: begin
        s = states_i[2*n_nine +: 2];
        if (cnt_i.nine == 4'd0) begin
          slot_o = sync_slot(long_sync);
        end else begin
          slot_o.is_sync      = 1'b0;
          slot_o.is_passthru  = 1'b0;
          slot_o.slot_channel = {1'b0, n_nine};
          slot_o.pulse_width  = (s == msps_pkg::SW_STEADY || s == msps_pkg::SW_BLINK1)
                                ? lvl_low : cfg_i.width_center;
        end
        cnt_o.nine = (cnt_i.nine >= 4'd8) ? 4'd0 : cnt_i.nine + 4'd1;
      end
      msps_pkg::MODE_SEVENTEEN: begin
        s = states_i[2*n_sub[2:0] +: 2];
        if (cnt_i.seventeen == 5'd0) begin
          slot_o = sync_slot(long_sync);
        end else begin
          slot_o.is_sync      = 1'b0;
          slot_o.is_passthru  = 1'b0;
          slot_o.slot_channel = n_sub;
          // Lower half reports steady bits, upper half blink1 bits.
          if (n_sub[3]) begin
            slot_o.pulse_width = (s == msps_pkg::SW_BLINK1) ? lvl_low : cfg_i.width_center;
          end else begin
            slot_o.pulse_width = (s == msps_pkg::SW_STEADY) ? lvl_low : cfg_i.width_center;
          end
        end
        cnt_o.seventeen = (cnt_i.seventeen >= 5'd16) ? 5'd0 : cnt_i.seventeen + 5'd1;
      end
      default: begin
        // Ten-slot frames; unused codes behave as the long-sync variant.
        if (cnt_i.ten < 4'd2) begin
          slot_o = sync_slot((cfg_i.frame_mode == msps_pkg::MODE_TEN_SHORT)
                             ? short_sync : long_sync);
        end else begin
          slot_o = three_level(n_ten);
        end
        cnt_o.ten = (cnt_i.ten >= 4'd9) ? 4'd0 : cnt_i.ten + 4'd1;
      end
    endcase
  end

endmodule

@@ rtl/multiswitch_ppm_slot_sequencer.sv @@
// Top level of the multi-switch PPM slot sequencer.
// A request accepted into the input register moves on to the result register once that register is free.
// Throughput: one request per cycle while the output is not stalled; an input register and a result register
// let a new request enter while a finished result still waits downstream.
// Reset clears all configuration registers, slot counters and valid flags.
module multiswitch_ppm_slot_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] switch_states_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pulse_width_o,
  output logic        is_sync_o,
  output logic        is_passthru_o,
  output logic [3:0]  slot_channel_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  `include "multiswitch_ppm_slot_sequencer_assert.svh"

  msps_pkg::cfg_t  cfg_q;
  msps_pkg::cnt_t  cnt_q;
  msps_pkg::cnt_t  cnt_d;
  msps_pkg::slot_t slot_d;
  msps_pkg::slot_t res_q;
  logic            s1_valid_q;
  logic [15:0]     s1_states_q;
  logic            out_valid_q;
  logic            out_free;
  logic            s1_move;
  logic            in_acc;

  // Handshake: the input register drains whenever the result register frees up.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        msps_pkg::REG_FRAME_MODE:    cfg_q.frame_mode    <= cfg_data_i[2:0];
        msps_pkg::REG_SYNC_OFFSET:   cfg_q.sync_offset   <= cfg_data_i;
        msps_pkg::REG_SWITCH_OFFSET: cfg_q.switch_offset <= cfg_data_i;
        msps_pkg::REG_WIDTH_MAX:     cfg_q.width_max     <= cfg_data_i;
        msps_pkg::REG_WIDTH_MIN:     cfg_q.width_min     <= cfg_data_i;
        msps_pkg::REG_WIDTH_CENTER:  cfg_q.width_center  <= cfg_data_i;
        msps_pkg::REG_PASSTHRU_MASK: cfg_q.passthru_mask <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_states_q <= switch_states_i;
    end
  end

  msps_slot_gen u_slot_gen (
    .cfg_i    (cfg_q),
    .cnt_i    (cnt_q),
    .states_i (s1_states_q),
    .slot_o   (slot_d),
    .cnt_o    (cnt_d)
  );

  // Slot counters advance as each request moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (s1_move) begin
      cnt_q <= cnt_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      res_q <= slot_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pulse_width_o  = res_q.pulse_width;
  assign is_sync_o      = res_q.is_sync;
  assign is_passthru_o  = res_q.is_passthru;
  assign slot_channel_o = res_q.slot_channel;

  // Checks on the slot logic and the pipeline.
  `MSPS_ASSERT_IMP(a_sync_clean, clk_i, rst_ni, out_valid_q && res_q.is_sync,
    !res_q.is_passthru && res_q.slot_channel == 4'd0, "sync slot carries channel data")
  `MSPS_ASSERT_IMP(a_passthru_zero, clk_i, rst_ni, out_valid_q && res_q.is_passthru,
    res_q.pulse_width == 16'd0 && !res_q.slot_channel[3], "pass-through slot has a width")
  `MSPS_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1,
    cnt_q.ten <= 4'd9 && cnt_q.nine <= 4'd8 && cnt_q.six <= 3'd5 &&
    cnt_q.seventeen <= 5'd16, "slot counter out of range")
  `MSPS_ASSERT_NEXT(a_move_fills, clk_i, rst_ni, s1_move,
    out_valid_q, "moved request did not reach the result register")

endmodule

@@ bench/multiswitch_ppm_slot_sequencer_checker.sv @@
// Checker that predicts and compares every slot result of the multi-switch slot sequencer.
module multiswitch_ppm_slot_sequencer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [15:0] switch_states_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] pulse_width_i,
  input  logic        is_sync_i,
  input  logic        is_passthru_i,
  input  logic [3:0]  slot_channel_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int unsigned slots_pending_o,
  output int unsigned mismatch_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the registers and of the per-length slot counters.
  msps_pkg::cfg_t  shadow;
  msps_pkg::cnt_t  pos;
  msps_pkg::slot_t slot_expect_q[$];
  int unsigned     pending = 0;
  int unsigned     mismatches = 0;

  assign slots_pending_o  = pending;
  assign mismatch_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("[%0t] slot check: %s", $time, msg);
    mismatches++;
  endtask

  // A sync slot carries only its width.
  function automatic msps_pkg::slot_t sync_slot(input logic [15:0] width);
    msps_pkg::slot_t s;
    s = '0;
    s.pulse_width = width;
    s.is_sync = 1'b1;
    return s;
  endfunction

  // Three-level switch slot, unless the switch forwards a live bus channel.
  function automatic msps_pkg::slot_t level_slot(input logic [15:0] states,
                                                 input logic [2:0] n);
    msps_pkg::slot_t s;
    s = '0;
    s.slot_channel = {1'b0, n};
    if (shadow.passthru_mask[n]) begin
      s.is_passthru = 1'b1;
    end else begin
      case (states[2*n +: 2])
        msps_pkg::SW_STEADY: s.pulse_width = shadow.width_max - shadow.switch_offset;
        msps_pkg::SW_BLINK1: s.pulse_width = shadow.width_min + shadow.switch_offset;
        default:             s.pulse_width = shadow.width_center;
      endcase
    end
    return s;
  endfunction

  // Short-only slot: either the short pulse or neutral.
  function automatic msps_pkg::slot_t short_slot(input logic hit, input logic [3:0] ch);
    msps_pkg::slot_t s;
    s = '0;
    s.slot_channel = ch;
    s.pulse_width = hit ? shadow.width_min + shadow.switch_offset : shadow.width_center;
    return s;
  endfunction

  // Result of the next slot for the active mode at the current counter position.
  function automatic msps_pkg::slot_t next_slot(input logic [15:0] states);
    logic [15:0] long_sync;
    logic [15:0] short_sync;
    logic [3:0]  i;
    logic [2:0]  n;
    logic [1:0]  st;
    long_sync  = shadow.width_max + shadow.sync_offset;
    short_sync = shadow.width_min - shadow.sync_offset;
    case (shadow.frame_mode)
      msps_pkg::MODE_SIX: begin
        n = pos.six - 3'd2;
        return (pos.six < 3'd2) ? sync_slot(long_sync) : level_slot(states, n);
      end
      msps_pkg::MODE_NINE_REV: begin
        // Switches run from the last one down to the first.
        n = 3'(4'd8 - pos.nine);
        return (pos.nine == 4'd0) ? sync_slot(short_sync) : level_slot(states, n);
      end
      msps_pkg::MODE_NINE_SHORT: begin
        if (pos.nine == 4'd0) return sync_slot(long_sync);
        i = pos.nine - 4'd1;
        st = states[2*i +: 2];
        return short_slot(st == msps_pkg::SW_STEADY || st == msps_pkg::SW_BLINK1, i);
      end
      msps_pkg::MODE_SEVENTEEN: begin
        if (pos.seventeen == 5'd0) return sync_slot(long_sync);
        // Sub-slots 0..7 show the steady bits, 8..15 the blink1 bits.
        i = 4'(pos.seventeen - 5'd1);
        st = states[2*i[2:0] +: 2];
        return short_slot(i[3] ? st == msps_pkg::SW_BLINK1 : st == msps_pkg::SW_STEADY, i);
      end
      default: begin
        // Ten-slot modes; the unused codes fall in here as well.
        n = 3'(pos.ten - 4'd2);
        if (pos.ten < 4'd2)
          return sync_slot(shadow.frame_mode == msps_pkg::MODE_TEN_SHORT
                           ? short_sync : long_sync);
        return level_slot(states, n);
      end
    endcase
  endfunction

  // Only the counter of the active frame length moves.
  task automatic advance_position();
    case (shadow.frame_mode)
      msps_pkg::MODE_SIX: pos.six = (pos.six >= 3'd5) ? 3'd0 : pos.six + 3'd1;
      msps_pkg::MODE_NINE_REV, msps_pkg::MODE_NINE_SHORT: begin
        pos.nine = (pos.nine >= 4'd8) ? 4'd0 : pos.nine + 4'd1;
      end
      msps_pkg::MODE_SEVENTEEN: begin
        pos.seventeen = (pos.seventeen >= 5'd16) ? 5'd0 : pos.seventeen + 5'd1;
      end
      default: pos.ten = (pos.ten >= 4'd9) ? 4'd0 : pos.ten + 4'd1;
    endcase
  endtask

  // Track register writes, compare results, then predict new requests.
  always @(posedge clk_i or negedge rst_ni) begin : track
    msps_pkg::slot_t want;
    if (!rst_ni) begin
      shadow = '0;
      pos = '0;
      slot_expect_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          msps_pkg::REG_FRAME_MODE:    shadow.frame_mode    = cfg_data_i[2:0];
          msps_pkg::REG_SYNC_OFFSET:   shadow.sync_offset   = cfg_data_i;
          msps_pkg::REG_SWITCH_OFFSET: shadow.switch_offset = cfg_data_i;
          msps_pkg::REG_WIDTH_MAX:     shadow.width_max     = cfg_data_i;
          msps_pkg::REG_WIDTH_MIN:     shadow.width_min     = cfg_data_i;
          msps_pkg::REG_WIDTH_CENTER:  shadow.width_center  = cfg_data_i;
          msps_pkg::REG_PASSTHRU_MASK: shadow.passthru_mask = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (slot_expect_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = slot_expect_q.pop_front();
          if (pulse_width_i !== want.pulse_width)
            report_mismatch($sformatf("pulse_width got 0x%04h, expected 0x%04h",
                                      pulse_width_i, want.pulse_width));
          if (is_sync_i !== want.is_sync)
            report_mismatch($sformatf("is_sync got %b, expected %b", is_sync_i, want.is_sync));
          if (is_passthru_i !== want.is_passthru)
            report_mismatch($sformatf("is_passthru got %b, expected %b",
                                      is_passthru_i, want.is_passthru));
          if (slot_channel_i !== want.slot_channel)
            report_mismatch($sformatf("slot_channel got %0d, expected %0d",
                                      slot_channel_i, want.slot_channel));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        slot_expect_q.push_back(next_slot(switch_states_i));
        advance_position();
      end
    end
    pending = slot_expect_q.size();
  end

endmodule

@@ bench/tb_multiswitch_ppm_slot_sequencer.sv @@
// Stimulus and verdict for the multi-switch PPM slot sequencer testbench.
module tb_multiswitch_ppm_slot_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned RequestGoal = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [15:0] switch_states = '0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = msps_pkg::REG_FRAME_MODE;
  logic [15:0] cfg_data = '0;

  logic        in_stall;
  logic        out_valid;
  logic [15:0] pulse_width;
  logic        is_sync;
  logic        is_passthru;
  logic [3:0]  slot_channel;
  logic        cfg_ready;

  int unsigned slots_pending;
  int unsigned mismatch_count;
  int unsigned requests_sent = 0;
  int unsigned send_idle_pct = 10;
  int unsigned recv_idle_pct = 63;
  int unsigned hold_asked = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  always #5ns clk_i = ~clk_i;

  multiswitch_ppm_slot_sequencer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .switch_states_i (switch_states),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .pulse_width_o   (pulse_width),
    .is_sync_o       (is_sync),
    .is_passthru_o   (is_passthru),
    .slot_channel_o  (slot_channel),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  multiswitch_ppm_slot_sequencer_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .switch_states_i  (switch_states),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .pulse_width_i    (pulse_width),
    .is_sync_i        (is_sync),
    .is_passthru_i    (is_passthru),
    .slot_channel_i   (slot_channel),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .slots_pending_o  (slots_pending),
    .mismatch_count_o (mismatch_count)
  );

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_taken != hold_asked) begin
      hold_taken++;
      hold_left = HoldCycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[multiswitch_ppm_slot_sequencer] ERROR");
    $finish;
  end

  // Register write; the caller lowers valid after its last write.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic program_frame(input logic [2:0] mode, input logic [15:0] sync_off,
                               input logic [15:0] sw_off, input logic [15:0] wmax,
                               input logic [15:0] wmin, input logic [15:0] wcenter,
                               input logic [7:0] mask);
    write_reg(msps_pkg::REG_FRAME_MODE, {13'd0, mode});
    write_reg(msps_pkg::REG_SYNC_OFFSET, sync_off);
    write_reg(msps_pkg::REG_SWITCH_OFFSET, sw_off);
    write_reg(msps_pkg::REG_WIDTH_MAX, wmax);
    write_reg(msps_pkg::REG_WIDTH_MIN, wmin);
    write_reg(msps_pkg::REG_WIDTH_CENTER, wcenter);
    write_reg(msps_pkg::REG_PASSTHRU_MASK, {8'd0, mask});
    cfg_valid <= 1'b0;
  endtask

  // One request; idling rates follow the progress of the run.
  task automatic send_request(input logic [15:0] states);
    if (requests_sent < 140) begin
      send_idle_pct = 10;
      recv_idle_pct = 63;
    end else if (requests_sent < 280) begin
      send_idle_pct = 63;
      recv_idle_pct = 10;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    switch_states <= states;
    do @(posedge clk_i); while (in_stall);
    requests_sent++;
  endtask

  // Stop sending and wait until every predicted slot has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (slots_pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Width register values biased toward the wrap-around extremes.
  function automatic logic [15:0] pick_width();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Main sequence: directed frames, then random phases over all modes.
  initial begin : stimulus
    logic [15:0] directed_states[13];
    logic [1:0]  st;
    int unsigned phase;
    int unsigned count;
    logic [2:0]  mode;
    logic [7:0]  mask;

    directed_states = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'hE4E4, 16'h1B1B,
                        16'h0123, 16'hFEDC, 16'h3210, 16'hC96A, 16'h55AA, 16'hAA55,
                        16'h8001};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A few slots with every register still at its reset value.
    send_request(16'hFFFF);
    send_request(16'h0000);
    send_request(16'h9C63);
    drain();

    // Realistic widths; the first and last switches forward live channels.
    program_frame(msps_pkg::MODE_TEN_LONG, 16'd300, 16'd100, 16'd2000, 16'd1000,
                  16'd1500, 8'h81);
    foreach (directed_states[k]) send_request(directed_states[k]);
    drain();

    phase = 0;
    while (requests_sent < RequestGoal) begin
      // The first eight phases walk through every mode code, the unused ones too.
      mode = (phase < 8) ? phase[2:0] : 3'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0:       mask = 8'h00;
        1:       mask = 8'hFF;
        default: mask = 8'($urandom_range(0, 255));
      endcase
      program_frame(mode, pick_width(), pick_width(), pick_width(), pick_width(),
                    pick_width(), mask);
      if (phase % 5 == 2) hold_asked++;
      count = $urandom_range(15, 35);
      for (int unsigned k = 0; k < count; k++) begin
        if (phase % 4 == 3 && k == count / 2) drain();
        if ($urandom_range(0, 4) == 0) begin
          st = 2'($urandom_range(0, 3));
          send_request({8{st}});
        end else begin
          send_request(16'($urandom_range(0, 65535)));
        end
      end
      drain();
      phase++;
    end

    in_valid <= 1'b0;
    drain();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[multiswitch_ppm_slot_sequencer] OK");
    end else begin
      $display("[multiswitch_ppm_slot_sequencer] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/msps_pkg.sv
rtl/msps_slot_gen.sv
rtl/multiswitch_ppm_slot_sequencer.sv
bench/multiswitch_ppm_slot_sequencer_checker.sv
bench/tb_multiswitch_ppm_slot_sequencer.sv
